FILE: hw/rtl/mcwc_pkg.sv
`default_nettype none

package mcwc_pkg;

	// fixed field widths
	localparam int START_W    = 5;
	localparam int COUNT_W    = 21;
	localparam int LEN_W      = 5;
	localparam int MASK_W     = 20;
	localparam int CAP_W      = 5;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 20;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_POSITION_COUNT = 2'd0,
		REG_OCCUPANCY_MASK = 2'd1,
		REG_HEIGHT_CAP     = 2'd2
	} reg_index_t;

	// one classified request as it waits in the queue
	typedef struct packed {
		logic [START_W-1:0] entry_height;
		logic               trivial;
	} item_t;

	// walk engine states
	typedef enum logic {
		BK_IDLE,
		BK_WALK
	} back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mcwc_front.sv
`default_nettype none

module mcwc_front (
	input  wire logic                        start,
	input  wire logic [mcwc_pkg::START_W-1:0] entry_height,
	input  wire logic [mcwc_pkg::CAP_W-1:0]   cap_sat,
	input  wire logic                        queue_full,
	output logic                             busy,
	output logic                             push,
	output mcwc_pkg::item_t                  item
);

	// accept while the queue has room
	assign busy = queue_full;
	assign push = start && !queue_full;

	// a start above the cap can never reach a walk, mark it trivial
	always_comb begin
		item.entry_height = entry_height;
		item.trivial      = (entry_height > cap_sat);
	end

endmodule

`default_nettype wire

FILE: hw/rtl/mcwc_queue.sv
`default_nettype none

module mcwc_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire mcwc_pkg::item_t wr_item,
	input  wire logic            pop,
	output mcwc_pkg::item_t      rd_item,
	output logic                 not_empty,
	output logic                 full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mcwc_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_item   = mem_q[rd_ptr_q];

	// storage, no reset on payload
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue fill level did not rise on push");
	a_fill_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue fill level did not fall on pop");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill level beyond its depth");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/mcwc_back.sv
`default_nettype none

module mcwc_back #(
	parameter int MAX_CAP       = 16,
	parameter int POS_W         = 5
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [POS_W-1:0]            len_sat,
	input  wire logic [mcwc_pkg::MASK_W-1:0] occ_mask,
	input  wire logic [mcwc_pkg::CAP_W-1:0]  cap_sat,
	input  wire logic                        q_valid,
	input  wire mcwc_pkg::item_t             q_item,
	output logic                             q_pop,
	output logic                             done,
	output logic [mcwc_pkg::COUNT_W-1:0]     path_count
);

	localparam int CW = mcwc_pkg::COUNT_W;

	mcwc_pkg::back_state_t state_q;
	mcwc_pkg::back_state_t state_d;
	logic [POS_W-1:0]      pos_q;
	logic [POS_W-1:0]      pos_m1;
	logic                  occ;
	logic                  emit;
	logic                  stepping;
	logic [MAX_CAP:0]      lane_en;
	logic [CW-1:0]         cnt_q    [MAX_CAP+1];
	logic [CW-1:0]         cnt_step [MAX_CAP+1];
	logic [CW-1:0]         cnt_init [MAX_CAP+1];
	logic                  done_q;
	logic [CW-1:0]         path_count_q;

	// occupancy of the position being walked, positions past the mask are free
	assign pos_m1   = pos_q - 1'b1;
	assign occ      = 1'(occ_mask >> pos_m1);
	assign stepping = (state_q == mcwc_pkg::BK_WALK) && (pos_q != '0);

	// one lane per height, all moved together
	for (genvar g = 0; g <= MAX_CAP; g++) begin : g_lane
		logic [CW-1:0] from_below;
		logic [CW-1:0] from_above;
		if (g > 0) begin : g_below
			assign from_below = cnt_q[g-1];
		end else begin : g_floor
			assign from_below = '0;
		end
		if (g < MAX_CAP) begin : g_above
			assign from_above = cnt_q[g+1];
		end else begin : g_ceiling
			assign from_above = '0;
		end
		assign lane_en[g]  = (g <= int'(cap_sat));
		assign cnt_step[g] = lane_en[g] ? (from_below + from_above) : '0;
		assign cnt_init[g] = (!q_item.trivial && (int'(q_item.entry_height) == g)) ?
			CW'(1) : '0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mcwc_pkg::BK_IDLE: begin
				if (q_valid) begin
					state_d = mcwc_pkg::BK_WALK;
				end
			end
			mcwc_pkg::BK_WALK: begin
				if (pos_q == '0) begin
					state_d = mcwc_pkg::BK_IDLE;
				end
			end
			default: state_d = mcwc_pkg::BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop = 1'b0;
		emit  = 1'b0;
		unique case (state_q)
			mcwc_pkg::BK_IDLE: q_pop = q_valid;
			mcwc_pkg::BK_WALK: emit  = (pos_q == '0);
			default: begin
				q_pop = 1'b0;
				emit  = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcwc_pkg::BK_IDLE;
			pos_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (q_pop) begin
				pos_q <= len_sat;
			end else if (stepping) begin
				pos_q <= pos_m1;
			end
		end
	end

	// height counts and result, payload only
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cnt_q <= cnt_init;
		end else if (stepping && occ) begin
			cnt_q <= cnt_step;
		end
		if (emit) begin
			path_count_q <= cnt_q[0];
		end
	end

	assign done       = done_q;
	assign path_count = path_count_q;

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobes on consecutive cycles");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mcwc_pkg::BK_WALK) |-> (pos_q <= len_sat))
		else $error("position counter beyond walk length");
	a_load_len: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (pos_q == $past(len_sat)) && (state_q == mcwc_pkg::BK_WALK))
		else $error("walk did not start at the configured length");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/masked_capped_walk_counter_top.sv
`default_nettype none

// Bounded-height walk counter. A request is taken when start is high and busy
// is low; it waits in a two-entry queue and the walk engine then loads it,
// takes one step per walked position (the saturated position count, up to
// MAX_POSITIONS), updating every height count together, and hands over the
// count; it loads the next request only once it is back in idle. The count
// appears on path_count with done high for exactly one cycle and must be taken
// then; there is no way to hold it off.
// busy is high only while the queue is full. Registers are written through
// cfg_we/cfg_addr/cfg_wdata and should be changed only when no request is
// outstanding.
module masked_capped_walk_counter_top #(
	parameter int MAX_POSITIONS = 20,
	parameter int MAX_CAP       = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [mcwc_pkg::START_W-1:0]    entry_height,
	output logic                                 done,
	output logic [mcwc_pkg::COUNT_W-1:0]         path_count,
	input  wire logic                            cfg_we,
	input  wire logic [mcwc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [mcwc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int POS_W = $clog2(MAX_POSITIONS + 1);

	logic [mcwc_pkg::LEN_W-1:0]  position_count_q;
	logic [mcwc_pkg::MASK_W-1:0] occupancy_mask_q;
	logic [mcwc_pkg::CAP_W-1:0]  height_cap_q;
	logic [POS_W-1:0]            len_sat;
	logic [mcwc_pkg::CAP_W-1:0]  cap_sat;
	logic                        push;
	logic                        pop;
	logic                        queue_full;
	logic                        queue_valid;
	mcwc_pkg::item_t             wr_item;
	mcwc_pkg::item_t             rd_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_count_q <= mcwc_pkg::LEN_W'(14);
			occupancy_mask_q <= '0;
			height_cap_q     <= mcwc_pkg::CAP_W'(14);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				mcwc_pkg::REG_POSITION_COUNT:
					position_count_q <= cfg_wdata[mcwc_pkg::LEN_W-1:0];
				mcwc_pkg::REG_OCCUPANCY_MASK:
					occupancy_mask_q <= cfg_wdata[mcwc_pkg::MASK_W-1:0];
				mcwc_pkg::REG_HEIGHT_CAP:
					height_cap_q <= cfg_wdata[mcwc_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp length and cap to what the engine holds
	assign len_sat = (int'(position_count_q) > MAX_POSITIONS) ?
		POS_W'(MAX_POSITIONS) : POS_W'(position_count_q);
	assign cap_sat = (int'(height_cap_q) > MAX_CAP) ?
		mcwc_pkg::CAP_W'(MAX_CAP) : height_cap_q;

	mcwc_front u_front (
		.start        (start),
		.entry_height (entry_height),
		.cap_sat      (cap_sat),
		.queue_full   (queue_full),
		.busy         (busy),
		.push         (push),
		.item         (wr_item)
	);

	mcwc_queue #(
		.DEPTH (mcwc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (wr_item),
		.pop       (pop),
		.rd_item   (rd_item),
		.not_empty (queue_valid),
		.full      (queue_full)
	);

	mcwc_back #(
		.MAX_CAP       (MAX_CAP),
		.POS_W         (POS_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.len_sat    (len_sat),
		.occ_mask   (occupancy_mask_q),
		.cap_sat    (cap_sat),
		.q_valid    (queue_valid),
		.q_item     (rd_item),
		.q_pop      (pop),
		.done       (done),
		.path_count (path_count)
	);

endmodule

`default_nettype wire

FILE: tb/masked_capped_walk_counter_top_tb.sv
`timescale 1ns / 1ps

module masked_capped_walk_counter_top_tb;

	localparam int CLK_HALF       = 2;
	localparam int RESET_CYCLES   = 11;
	localparam int CYCLE_LIMIT    = 300000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int MAX_REPORTS    = 10;
	localparam int WALK_PHASES    = 9;
	localparam int PHASE_ITEMS    = 50;
	localparam int LIMIT_POSITIONS = 20;
	localparam int LIMIT_CAP      = 16;

	// index with no register behind it, written only as noise
	localparam logic [mcwc_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;

	// one line of the directed plan: either a register write or a request
	typedef struct packed {
		logic                            is_write;
		logic [mcwc_pkg::CFG_ADDR_W-1:0] addr;
		logic [mcwc_pkg::CFG_DATA_W-1:0] data;
		logic [mcwc_pkg::START_W-1:0]    height;
		logic                            known;
		logic [mcwc_pkg::COUNT_W-1:0]    count;
	} plan_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic [mcwc_pkg::START_W-1:0]    entry_height;
	logic                            done;
	logic [mcwc_pkg::COUNT_W-1:0]    path_count;
	logic                            cfg_we;
	logic [mcwc_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [mcwc_pkg::CFG_DATA_W-1:0] cfg_wdata;

	// register copies used by the walk predictor
	logic [mcwc_pkg::LEN_W-1:0]  walk_len;
	logic [mcwc_pkg::MASK_W-1:0] walk_mask;
	logic [mcwc_pkg::CAP_W-1:0]  walk_cap;

	logic [mcwc_pkg::COUNT_W-1:0] pending_counts[$];
	plan_row_t                    directed_plan[$];

	// hand-typed expectation for the request being driven
	logic                         fixed_known;
	logic [mcwc_pkg::COUNT_W-1:0] fixed_count;

	logic [mcwc_pkg::COUNT_W-1:0] oldest_count;
	int                           failures;
	int                           requests_sent;
	int                           counts_checked;
	int                           nonzero_counts;
	int                           cycle_count;
	bit                           quiet_sender;

	masked_capped_walk_counter_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.entry_height (entry_height),
		.done         (done),
		.path_count   (path_count),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	always #CLK_HALF clk = ~clk;

	// number of capped walks from a start height that finish at height zero
	function automatic logic [mcwc_pkg::COUNT_W-1:0] count_walks(
			input logic [mcwc_pkg::START_W-1:0] h0);
		int                           len;
		int                           cap;
		logic [mcwc_pkg::COUNT_W-1:0] cur[LIMIT_CAP+1];
		logic [mcwc_pkg::COUNT_W-1:0] nxt[LIMIT_CAP+1];
		len = (walk_len > LIMIT_POSITIONS) ? LIMIT_POSITIONS : int'(walk_len);
		cap = (walk_cap > LIMIT_CAP) ? LIMIT_CAP : int'(walk_cap);
		if (int'(h0) > cap)
			return '0;
		foreach (cur[h])
			cur[h] = '0;
		cur[h0] = mcwc_pkg::COUNT_W'(1);
		for (int p = len - 1; p >= 0; p--) begin
			if (walk_mask[p]) begin
				foreach (nxt[h])
					nxt[h] = '0;
				for (int h = 0; h <= cap; h++) begin
					if (h > 0)
						nxt[h-1] = nxt[h-1] + cur[h];
					if (h < cap)
						nxt[h+1] = nxt[h+1] + cur[h];
				end
				cur = nxt;
			end
		end
		return cur[0];
	endfunction

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// score each count against the oldest expectation, then log new transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_counts.size() == 0) begin
					note_failure($sformatf("path_count %0d with no request outstanding",
						path_count));
				end else begin
					oldest_count = pending_counts.pop_front();
					counts_checked++;
					if (oldest_count != 0)
						nonzero_counts++;
					if (path_count !== oldest_count)
						note_failure($sformatf("path_count expected %0d got %0d",
							oldest_count, path_count));
				end
			end
			if (start && !busy) begin
				if (fixed_known)
					pending_counts.push_back(fixed_count);
				else
					pending_counts.push_back(count_walks(entry_height));
			end
		end
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d counts outstanding",
				cycle_count, pending_counts.size());
			$display("masked_capped_walk_counter_top_tb: FAIL");
			$finish;
		end
	end

	// drive one request and hold it until the block takes it
	task automatic send_request(input logic [mcwc_pkg::START_W-1:0] h, input logic known,
			input logic [mcwc_pkg::COUNT_W-1:0] count);
		@(negedge clk);
		start        <= 1'b1;
		entry_height <= h;
		fixed_known  = known;
		fixed_count  = count;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic idle_for(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start        <= 1'b0;
			entry_height <= mcwc_pkg::START_W'($urandom);
		end
	endtask

	// stop sending and let every outstanding count come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		repeat (2)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [mcwc_pkg::CFG_ADDR_W-1:0] addr,
			input logic [mcwc_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		start     <= 1'b0;
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		case (addr)
			mcwc_pkg::REG_POSITION_COUNT: walk_len  = data[mcwc_pkg::LEN_W-1:0];
			mcwc_pkg::REG_OCCUPANCY_MASK: walk_mask = data[mcwc_pkg::MASK_W-1:0];
			mcwc_pkg::REG_HEIGHT_CAP:     walk_cap  = data[mcwc_pkg::CAP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we    <= 1'b0;
		cfg_addr  <= mcwc_pkg::CFG_ADDR_W'($urandom);
		cfg_wdata <= mcwc_pkg::CFG_DATA_W'($urandom);
	endtask

	function automatic plan_row_t write_row(input logic [mcwc_pkg::CFG_ADDR_W-1:0] addr,
			input logic [mcwc_pkg::CFG_DATA_W-1:0] data);
		plan_row_t r;
		r          = '0;
		r.is_write = 1'b1;
		r.addr     = addr;
		r.data     = data;
		return r;
	endfunction

	function automatic plan_row_t fixed_row(input int h, input int count);
		plan_row_t r;
		r        = '0;
		r.height = mcwc_pkg::START_W'(h);
		r.known  = 1'b1;
		r.count  = mcwc_pkg::COUNT_W'(count);
		return r;
	endfunction

	function automatic plan_row_t predicted_row(input int h);
		plan_row_t r;
		r        = '0;
		r.height = mcwc_pkg::START_W'(h);
		return r;
	endfunction

	// settings for one random phase, extremes first then mostly small walks
	task automatic set_phase(input int phase);
		logic [mcwc_pkg::LEN_W-1:0]  len;
		logic [mcwc_pkg::MASK_W-1:0] mask;
		logic [mcwc_pkg::CAP_W-1:0]  cap;
		case (phase)
			0: begin
				len  = mcwc_pkg::LEN_W'(20);
				mask = '1;
				cap  = mcwc_pkg::CAP_W'(16);
			end
			1: begin
				len  = mcwc_pkg::LEN_W'(1);
				mask = mcwc_pkg::MASK_W'($urandom);
				cap  = '0;
			end
			2: begin
				len  = mcwc_pkg::LEN_W'(31);
				mask = mcwc_pkg::MASK_W'($urandom);
				cap  = mcwc_pkg::CAP_W'(31);
			end
			3: begin
				len  = '0;
				mask = mcwc_pkg::MASK_W'($urandom);
				cap  = mcwc_pkg::CAP_W'($urandom_range(0, 16));
			end
			default: begin
				len  = ($urandom_range(0, 3) == 0) ? mcwc_pkg::LEN_W'($urandom_range(0, 31))
					: mcwc_pkg::LEN_W'($urandom_range(1, 12));
				mask = ($urandom_range(0, 4) == 0) ? '1 : mcwc_pkg::MASK_W'($urandom);
				cap  = ($urandom_range(0, 4) == 0) ? mcwc_pkg::CAP_W'($urandom_range(17, 31))
					: mcwc_pkg::CAP_W'($urandom_range(0, 16));
			end
		endcase
		// upper data bits carry noise on the narrow registers
		write_reg(mcwc_pkg::REG_POSITION_COUNT,
			{(mcwc_pkg::CFG_DATA_W-mcwc_pkg::LEN_W)'($urandom), len});
		write_reg(mcwc_pkg::REG_OCCUPANCY_MASK, mask);
		write_reg(mcwc_pkg::REG_HEIGHT_CAP,
			{(mcwc_pkg::CFG_DATA_W-mcwc_pkg::CAP_W)'($urandom), cap});
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_UNMAPPED, mcwc_pkg::CFG_DATA_W'($urandom));
	endtask

	// start height: mostly one that can still come down, sometimes anything
	function automatic logic [mcwc_pkg::START_W-1:0] pick_height();
		int reach;
		reach = (walk_len > LIMIT_POSITIONS) ? LIMIT_POSITIONS : int'(walk_len);
		if (walk_cap < reach)
			reach = int'(walk_cap);
		if ($urandom_range(0, 9) < 7)
			return mcwc_pkg::START_W'($urandom_range(0, reach));
		return mcwc_pkg::START_W'($urandom_range(0, 31));
	endfunction

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		entry_height = '0;
		cfg_we       = 1'b0;
		cfg_addr     = '0;
		cfg_wdata    = '0;
		fixed_known  = 1'b0;
		fixed_count  = '0;
		walk_len     = mcwc_pkg::LEN_W'(14);
		walk_mask    = '0;
		walk_cap     = mcwc_pkg::CAP_W'(14);
		failures       = 0;
		requests_sent  = 0;
		counts_checked = 0;
		nonzero_counts = 0;
		cycle_count    = 0;
		quiet_sender   = 1'b0;

		// directed plan: reset settings, all-occupied, zero and oversized walks,
		// zero and oversized cap, mask bits past the walk, start too high
		directed_plan.push_back(fixed_row(0, 1));
		directed_plan.push_back(fixed_row(5, 0));
		directed_plan.push_back(fixed_row(14, 0));
		directed_plan.push_back(fixed_row(15, 0));
		directed_plan.push_back(fixed_row(31, 0));
		directed_plan.push_back(write_row(mcwc_pkg::REG_OCCUPANCY_MASK, 20'hFFFFF));
		directed_plan.push_back(predicted_row(0));
		directed_plan.push_back(predicted_row(13));
		directed_plan.push_back(predicted_row(14));
		directed_plan.push_back(write_row(mcwc_pkg::REG_POSITION_COUNT, 20'd0));
		directed_plan.push_back(fixed_row(0, 1));
		directed_plan.push_back(fixed_row(3, 0));
		directed_plan.push_back(write_row(mcwc_pkg::REG_POSITION_COUNT, 20'd31));
		directed_plan.push_back(write_row(mcwc_pkg::REG_HEIGHT_CAP, 20'd31));
		directed_plan.push_back(predicted_row(0));
		directed_plan.push_back(predicted_row(16));
		directed_plan.push_back(fixed_row(17, 0));
		directed_plan.push_back(write_row(mcwc_pkg::REG_HEIGHT_CAP, 20'd0));
		directed_plan.push_back(fixed_row(0, 0));
		directed_plan.push_back(fixed_row(1, 0));
		directed_plan.push_back(write_row(mcwc_pkg::REG_POSITION_COUNT, 20'd3));
		directed_plan.push_back(write_row(mcwc_pkg::REG_OCCUPANCY_MASK, 20'hFFFF8));
		directed_plan.push_back(write_row(mcwc_pkg::REG_HEIGHT_CAP, 20'd5));
		directed_plan.push_back(fixed_row(0, 1));
		directed_plan.push_back(fixed_row(2, 0));
		directed_plan.push_back(write_row(mcwc_pkg::REG_POSITION_COUNT, 20'd4));
		directed_plan.push_back(write_row(mcwc_pkg::REG_OCCUPANCY_MASK, 20'h0000F));
		directed_plan.push_back(write_row(mcwc_pkg::REG_HEIGHT_CAP, 20'd16));
		directed_plan.push_back(fixed_row(5, 0));
		directed_plan.push_back(fixed_row(4, 1));
		directed_plan.push_back(predicted_row(2));

		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, registers change only once the block has gone quiet
		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_write) begin
				drain();
				write_reg(directed_plan[i].addr, directed_plan[i].data);
			end else begin
				send_request(directed_plan[i].height, directed_plan[i].known,
					directed_plan[i].count);
			end
		end

		// random part, one register setting per phase, no idling in the last
		for (int phase = 0; phase < WALK_PHASES; phase++) begin
			drain();
			set_phase(phase);
			quiet_sender = (phase == WALK_PHASES - 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 4 && n == PHASE_ITEMS / 2)
					drain();
				if (!quiet_sender && $urandom_range(0, 3) == 0)
					idle_for($urandom_range(1, 16));
				send_request(pick_height(), 1'b0, '0);
			end
		end

		drain();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (pending_counts.size() != 0)
			note_failure($sformatf("%0d counts never arrived", pending_counts.size()));

		$display("%0d walk requests over %0d register settings plus directed cases",
			requests_sent, WALK_PHASES);
		$display("%0d counts checked, %0d of them non-zero, %0d failures",
			counts_checked, nonzero_counts, failures);
		if (failures == 0)
			$display("masked_capped_walk_counter_top_tb: PASS");
		else
			$display("masked_capped_walk_counter_top_tb: FAIL");
		$finish;
	end

endmodule
